### design/priority_sorted_alarm_table_assert.svh
// Assertion macros for the priority sorted alarm table.
// Each macro expands to one labelled concurrent assertion on the rising clock edge.
`ifndef PRIORITY_SORTED_ALARM_TABLE_ASSERT_SVH
`define PRIORITY_SORTED_ALARM_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/psat_pkg.sv
`timescale 1ns / 1ps

package psat_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam logic [7:0] EMPTY_CODE_DEF = 8'd0;

   localparam int KIND_W  = 2;
   localparam int CODE_W  = 8;
   localparam int PRIO_W  = 8;
   localparam int INDEX_W = 8;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic compare;
      logic decide;
      logic apply;
      logic report;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic modify;
   } status_type;

endpackage

### design/priority_sorted_alarm_table.sv
// Sequence: after a request is accepted, the controller walks scan (compare), find (decide),
//   move (apply) and report when the table changes, and scan, find and report for a query
//   or no-op; the result strobe is registered from the report step. A new request is taken
//   only once busy has dropped after the report step of the previous one.
// Reset: synchronous, active high; empties every entry and drops any transfer in flight.
// The receiver cannot stall: rsp_valid is high for one cycle only for each result.
`timescale 1ns / 1ps

module priority_sorted_alarm_table #(
   parameter int                          TABLE_DEPTH = psat_pkg::TABLE_DEPTH_DEF,
   parameter logic [psat_pkg::CODE_W-1:0] EMPTY_CODE  = psat_pkg::EMPTY_CODE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [psat_pkg::KIND_W-1:0]      req_kind,
   input  logic [psat_pkg::CODE_W-1:0]      req_alarm_code,
   input  logic [psat_pkg::PRIO_W-1:0]      req_priority_req,
   input  logic [psat_pkg::INDEX_W-1:0]     req_read_index,
   output logic                             rsp_valid,
   output logic [psat_pkg::CODE_W-1:0]      rsp_top_code,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] rsp_alarm_count,
   output logic                             rsp_any_active,
   output logic [psat_pkg::CODE_W-1:0]      rsp_code_at_index,
   output logic                             rsp_code_present,
   output logic                             rsp_add_stored
);

   // Controller and datapath talk through these two groups only.
   psat_pkg::cmd_type    cmd;
   psat_pkg::status_type status;

   // The controller sequences one request at a time and holds busy until
   // the report step has loaded the result registers.
   psat_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath keeps the sorted table in flip-flops. Compare every entry
   // against the request in parallel, pick the insert or removal slot with a
   // priority encoder, then shift the entries below that slot in one step.
   psat_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .EMPTY_CODE  (EMPTY_CODE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_alarm_code    (req_alarm_code),
      .req_priority_req  (req_priority_req),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_top_code      (rsp_top_code),
      .rsp_alarm_count   (rsp_alarm_count),
      .rsp_any_active    (rsp_any_active),
      .rsp_code_at_index (rsp_code_at_index),
      .rsp_code_present  (rsp_code_present),
      .rsp_add_stored    (rsp_add_stored)
   );

`include "priority_sorted_alarm_table_assert.svh"

   // A result transfer only appears once the controller has gone idle.
   `PSAT_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")

   // An accepted request is never answered in the very next cycle.
   `PSAT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid,
      "accepted request did not raise busy")

   // The reported count is nonzero exactly when the active flag is set.
   `PSAT_ASSERT_NOW(a_count_active, clock, reset, rsp_valid,
      rsp_any_active == (rsp_alarm_count != '0), "count disagrees with active flag")

   // The top entry is empty exactly when nothing is active.
   `PSAT_ASSERT_NOW(a_top_active, clock, reset, rsp_valid,
      rsp_any_active == (rsp_top_code != EMPTY_CODE), "top code disagrees with active flag")

endmodule

### design/psat_ctrl.sv
`timescale 1ns / 1ps

module psat_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  psat_pkg::status_type  status,
   output psat_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIND,
      ST_MOVE,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               busy_in  = 1'b1;
            end
         end
         ST_SCAN:   state_in = ST_FIND;
         ST_FIND:   state_in = status.modify ? ST_MOVE : ST_REPORT;
         ST_MOVE:   state_in = ST_REPORT;
         ST_REPORT: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy        = busy_ff;
   assign cmd.latch   = (state_ff == ST_IDLE) && start && !busy_ff;
   assign cmd.compare = (state_ff == ST_SCAN);
   assign cmd.decide  = (state_ff == ST_FIND);
   assign cmd.apply   = (state_ff == ST_MOVE);
   assign cmd.report  = (state_ff == ST_REPORT);

endmodule

### design/psat_datapath.sv
`timescale 1ns / 1ps

module psat_datapath #(
   parameter int                          TABLE_DEPTH = psat_pkg::TABLE_DEPTH_DEF,
   parameter logic [psat_pkg::CODE_W-1:0] EMPTY_CODE  = psat_pkg::EMPTY_CODE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  psat_pkg::cmd_type                    cmd,
   output psat_pkg::status_type                 status,
   input  logic [psat_pkg::KIND_W-1:0]          req_kind,
   input  logic [psat_pkg::CODE_W-1:0]          req_alarm_code,
   input  logic [psat_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic [psat_pkg::INDEX_W-1:0]         req_read_index,
   output logic                                 rsp_valid,
   output logic [psat_pkg::CODE_W-1:0]          rsp_top_code,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     rsp_alarm_count,
   output logic                                 rsp_any_active,
   output logic [psat_pkg::CODE_W-1:0]          rsp_code_at_index,
   output logic                                 rsp_code_present,
   output logic                                 rsp_add_stored
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   // Lowest set position of a vector.
   function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_DEPTH-1:0] vec);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = IDX_W'(i);
         end
      end
      return pos;
   endfunction

   logic [psat_pkg::CODE_W-1:0] code_ff [TABLE_DEPTH];
   logic [psat_pkg::PRIO_W-1:0] prio_ff [TABLE_DEPTH];

   logic [psat_pkg::KIND_W-1:0] kind_ff;
   logic [psat_pkg::CODE_W-1:0] req_code_ff;
   logic [psat_pkg::PRIO_W-1:0] req_prio_ff;
   logic [IDX_W-1:0]            read_idx_ff, read_idx_in;

   logic [TABLE_DEPTH-1:0] match_vec, empty_vec, match_ff, lower_ff;
   logic                   code_valid, add_ok, clear_ok;
   logic [IDX_W-1:0]       pos_ff;
   logic                   do_add_ff, do_clear_ff, stored_ff;

   logic                        rsp_valid_ff;
   logic [psat_pkg::CODE_W-1:0] top_code_ff, code_at_index_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        any_active_ff, present_ff, add_stored_ff;

   always_comb begin
      if ({1'b0, req_read_index} > (psat_pkg::INDEX_W+1)'(TABLE_DEPTH - 1)) begin
         read_idx_in = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         read_idx_in = req_read_index[IDX_W-1:0];
      end
   end

   // Latch the request on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff     <= req_kind;
         req_code_ff <= req_alarm_code;
         req_prio_ff <= req_priority_req;
         read_idx_ff <= read_idx_in;
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_vec[i] = (code_ff[i] == req_code_ff);
         empty_vec[i] = (code_ff[i] == EMPTY_CODE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= match_vec;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            lower_ff[i] <= (prio_ff[i] < req_prio_ff);
         end
      end
   end

   assign code_valid = (req_code_ff != EMPTY_CODE);

   always_comb begin
      add_ok   = 1'b0;
      clear_ok = 1'b0;
      case (kind_ff)
         psat_pkg::KIND_ADD:   add_ok   = code_valid && !(|match_ff) && lower_ff[TABLE_DEPTH-1];
         psat_pkg::KIND_CLEAR: clear_ok = code_valid && (|match_ff);
         psat_pkg::KIND_QUERY: ;
         default: ;
      endcase
   end

   assign status.modify = add_ok || clear_ok;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         pos_ff      <= add_ok ? first_set(lower_ff) : first_set(match_ff);
         do_add_ff   <= add_ok;
         do_clear_ff <= clear_ok;
         stored_ff   <= add_ok;
      end
   end

   // Insert shifts entries below the slot down; clear shifts them up.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
      always_ff @(posedge clock) begin
         if (reset) begin
            code_ff[g] <= EMPTY_CODE;
            prio_ff[g] <= '0;
         end else if (cmd.apply && (IDX_W'(g) >= pos_ff)) begin
            if (do_add_ff) begin
               if (IDX_W'(g) == pos_ff) begin
                  code_ff[g] <= req_code_ff;
                  prio_ff[g] <= req_prio_ff;
               end else if (g > 0) begin
                  code_ff[g] <= code_ff[(g > 0) ? g - 1 : 0];
                  prio_ff[g] <= prio_ff[(g > 0) ? g - 1 : 0];
               end
            end else if (do_clear_ff) begin
               if (g == TABLE_DEPTH - 1) begin
                  code_ff[g] <= EMPTY_CODE;
                  prio_ff[g] <= '0;
               end else begin
                  code_ff[g] <= code_ff[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                  prio_ff[g] <= prio_ff[(g < TABLE_DEPTH - 1) ? g + 1 : g];
               end
            end
         end
      end
   end

   always_comb begin
      if (|empty_vec) begin
         count_in = CNT_W'(first_set(empty_vec));
      end else begin
         count_in = CNT_W'(TABLE_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         top_code_ff      <= code_ff[0];
         count_ff         <= count_in;
         any_active_ff    <= !empty_vec[0];
         code_at_index_ff <= code_ff[read_idx_ff];
         present_ff       <= code_valid && (|match_vec);
         add_stored_ff    <= stored_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.report;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_top_code      = top_code_ff;
   assign rsp_alarm_count   = count_ff;
   assign rsp_any_active    = any_active_ff;
   assign rsp_code_at_index = code_at_index_ff;
   assign rsp_code_present  = present_ff;
   assign rsp_add_stored    = add_stored_ff;

endmodule
